>>> sv/edge_timestamp_overwrite_ring_macros.svh
// Assertion macros for the edge timestamp ring.
`ifndef EDGE_TIMESTAMP_OVERWRITE_RING_MACROS_SVH
`define EDGE_TIMESTAMP_OVERWRITE_RING_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ETOR_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define ETOR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/etor_pkg.sv
// Shared types and constants for the edge timestamp ring.
package etor_pkg;

    localparam int RING_DEPTH_DEF = 512;
    localparam int MAX_READ_DEF   = 64;

    // Operation codes of a command
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Command transfer
    typedef struct packed {
        logic        op;
        logic [31:0] edge_time;
        logic        edge_level;
        logic [6:0]  max_count;
    } cmd_t;

    // Result transfer
    typedef struct packed {
        logic [31:0] sample_time;
        logic        sample_level;
        logic        is_empty;
        logic        last_of_run;
    } result_t;

    // One stored sample
    typedef struct packed {
        logic [31:0] stamp;
        logic        level;
    } entry_t;

    // Operation of the shared index unit
    typedef enum logic {
        AOP_ADD = 1'b0,
        AOP_SUB = 1'b1
    } addr_op_t;

endpackage

>>> sv/etor_addr_unit.sv
// Shared modulo-depth add/subtract unit for ring indexes.
module etor_addr_unit #(
    parameter int RING_DEPTH = etor_pkg::RING_DEPTH_DEF
) (
    input  logic [$clog2(RING_DEPTH)-1:0]   a,
    input  logic [$clog2(RING_DEPTH+1)-1:0] b,
    input  etor_pkg::addr_op_t              op,
    output logic [$clog2(RING_DEPTH)-1:0]   y
);

    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam logic [FILL_W:0] DEPTH_X = (FILL_W + 1)'(RING_DEPTH);

    logic [FILL_W:0] a_x;
    logic [FILL_W:0] b_x;
    logic [FILL_W:0] t;
    logic [FILL_W:0] y_x;

    // Add or subtract, then fold back into the ring once
    always_comb
    begin
        a_x = (FILL_W + 1)'(a);
        b_x = (FILL_W + 1)'(b);
        if (op == etor_pkg::AOP_SUB)
        begin
            t   = a_x - b_x;
            y_x = t[FILL_W] ? t + DEPTH_X : t;
        end
        else
        begin
            t   = a_x + b_x;
            y_x = (t >= DEPTH_X) ? t - DEPTH_X : t;
        end
        y = y_x[IDX_W-1:0];
    end

endmodule

>>> sv/etor_ring_mem.sv
// Sample store: one write port, one registered read port.
module etor_ring_mem #(
    parameter int RING_DEPTH = etor_pkg::RING_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(RING_DEPTH)-1:0] wr_addr,
    input  etor_pkg::entry_t              wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(RING_DEPTH)-1:0] rd_addr,
    output etor_pkg::entry_t              rd_data
);

    etor_pkg::entry_t mem_reg [RING_DEPTH];
    etor_pkg::entry_t rd_data_reg;

    // Write a captured sample
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read a sample into the output register
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/edge_timestamp_overwrite_ring.sv
// Top level of the edge timestamp ring: sequencer, store and index unit.
//
//  channel   signals                        handshake
//  command   start, busy, cmd               taken when start & !busy
//  result    result_strobe, result          one cycle, no back-pressure
//  config    cfg_valid, cfg_ready, cfg_data taken when cfg_valid & cfg_ready
//
// An edge event leaves busy low.
// A read streams its n samples at one sample a cycle from the store's single
// read port; an empty read gives a single flagged result.
// Samples appear in the cycle after their store read; the receiver cannot stall.
// Reset clears index, count and enable; the store itself is not cleared.
`include "edge_timestamp_overwrite_ring_macros.svh"

module edge_timestamp_overwrite_ring #(
    parameter int RING_DEPTH = etor_pkg::RING_DEPTH_DEF,
    parameter int MAX_READ   = etor_pkg::MAX_READ_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  etor_pkg::cmd_t    cmd,
    output logic              result_strobe,
    output etor_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);

    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int CNT_W  = $clog2(MAX_READ + 1);
    localparam int CMP_W  = (FILL_W > CNT_W) ? FILL_W : CNT_W;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_DEPTH);
    localparam logic [6:0]        READ_CAP  = 7'(MAX_READ);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_READ = 3'b100
    } state_t;

    state_t            state_reg,   state_next;
    logic              enable_reg,  enable_next;
    logic [IDX_W-1:0]  wr_idx_reg,  wr_idx_next;
    logic [FILL_W-1:0] fill_reg,    fill_next;
    logic [CNT_W-1:0]  req_reg,     req_next;
    logic [IDX_W-1:0]  addr_reg,    addr_next;
    logic [CNT_W-1:0]  cnt_reg,     cnt_next;
    logic              rd_v_reg,    rd_v_next;
    logic              rd_last_reg, rd_last_next;
    logic              emp_v_reg,   emp_v_next;

    logic               accept;
    logic               edge_acc;
    logic               cfg_fire;
    logic [6:0]         req_clip;
    logic [CMP_W-1:0]   fill_x;
    logic [CMP_W-1:0]   req_x;
    logic [CMP_W-1:0]   n_x;
    logic [IDX_W-1:0]   unit_a;
    logic [FILL_W-1:0]  unit_b;
    etor_pkg::addr_op_t unit_op;
    logic [IDX_W-1:0]   unit_y;
    logic               rd_en;
    etor_pkg::entry_t   wr_data;
    etor_pkg::entry_t   rd_data;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;
    assign edge_acc  = accept & (cmd.op == etor_pkg::OP_EDGE) & enable_reg;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign rd_en     = (state_reg == ST_READ);

    assign wr_data.stamp = cmd.edge_time;
    assign wr_data.level = cmd.edge_level;

    // Clip the requested count to the read limit
    assign req_clip = (cmd.max_count > READ_CAP) ? READ_CAP : cmd.max_count;

    // Samples to return: the smaller of the fill count and the request
    assign fill_x = CMP_W'(fill_reg);
    assign req_x  = CMP_W'(req_reg);
    assign n_x    = (fill_x < req_x) ? fill_x : req_x;

    // Steer the shared index unit by sequencer state
    always_comb
    begin
        unit_a  = wr_idx_reg;
        unit_b  = FILL_W'(1);
        unit_op = etor_pkg::AOP_ADD;
        case (state_reg)
            ST_IDLE:
            begin
                unit_a  = wr_idx_reg;
                unit_b  = FILL_W'(1);
                unit_op = etor_pkg::AOP_ADD;
            end
            ST_CALC:
            begin
                unit_a  = wr_idx_reg;
                unit_b  = fill_reg;
                unit_op = etor_pkg::AOP_SUB;
            end
            ST_READ:
            begin
                unit_a  = addr_reg;
                unit_b  = FILL_W'(1);
                unit_op = etor_pkg::AOP_ADD;
            end
            default:
            begin
                unit_a  = wr_idx_reg;
                unit_b  = FILL_W'(1);
                unit_op = etor_pkg::AOP_ADD;
            end
        endcase
    end

    etor_addr_unit #(
        .RING_DEPTH (RING_DEPTH)
    ) u_addr_unit (
        .a  (unit_a),
        .b  (unit_b),
        .op (unit_op),
        .y  (unit_y)
    );

    etor_ring_mem #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring_mem (
        .clk     (clk),
        .wr_en   (edge_acc),
        .wr_addr (wr_idx_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // Sequencer: capture, set up a read, stream samples
    always_comb
    begin
        state_next   = state_reg;
        enable_next  = enable_reg;
        wr_idx_next  = wr_idx_reg;
        fill_next    = fill_reg;
        req_next     = req_reg;
        addr_next    = addr_reg;
        cnt_next     = cnt_reg;
        rd_v_next    = 1'b0;
        rd_last_next = rd_last_reg;
        emp_v_next   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (edge_acc)
                begin
                    wr_idx_next = unit_y;
                    if (fill_reg != FILL_FULL)
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
                if (accept && (cmd.op == etor_pkg::OP_READ))
                begin
                    req_next   = CNT_W'(req_clip);
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (n_x == '0)
                begin
                    emp_v_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next  = unit_y;
                    cnt_next   = CNT_W'(n_x);
                    fill_next  = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                addr_next    = unit_y;
                cnt_next     = cnt_reg - CNT_W'(1);
                rd_v_next    = 1'b1;
                rd_last_next = (cnt_reg == CNT_W'(1));
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Enabling capture restarts the ring
        if (cfg_fire)
        begin
            enable_next = cfg_data;
            if (cfg_data && !enable_reg)
            begin
                wr_idx_next = '0;
                fill_next   = '0;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            enable_reg  <= 1'b0;
            wr_idx_reg  <= '0;
            fill_reg    <= '0;
            req_reg     <= '0;
            addr_reg    <= '0;
            cnt_reg     <= '0;
            rd_v_reg    <= 1'b0;
            rd_last_reg <= 1'b0;
            emp_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            enable_reg  <= enable_next;
            wr_idx_reg  <= wr_idx_next;
            fill_reg    <= fill_next;
            req_reg     <= req_next;
            addr_reg    <= addr_next;
            cnt_reg     <= cnt_next;
            rd_v_reg    <= rd_v_next;
            rd_last_reg <= rd_last_next;
            emp_v_reg   <= emp_v_next;
        end
    end

    // Drive the result transfer from the store or as an empty marker
    assign result_strobe = rd_v_reg | emp_v_reg;
    always_comb
    begin
        if (rd_v_reg)
        begin
            result.sample_time  = rd_data.stamp;
            result.sample_level = rd_data.level;
            result.is_empty     = 1'b0;
            result.last_of_run  = rd_last_reg;
        end
        else
        begin
            result.sample_time  = '0;
            result.sample_level = 1'b0;
            result.is_empty     = 1'b1;
            result.last_of_run  = 1'b1;
        end
    end

    // Checks on the sequencer
    `ETOR_ASSERT_SAME(a_one_source, clk, rst_n, rd_v_reg, !emp_v_reg, "sample and empty marker together")
    `ETOR_ASSERT_NEXT(a_read_setup, clk, rst_n, accept && (cmd.op == etor_pkg::OP_READ), state_reg == ST_CALC, "read not set up")
    `ETOR_ASSERT_SAME(a_last_ends, clk, rst_n, rd_v_reg && rd_last_reg, state_reg != ST_READ, "read runs past last sample")
    `ETOR_ASSERT_SAME(a_drained, clk, rst_n, rd_v_reg, fill_reg == '0, "store not emptied by read")

endmodule

>>> bench/tb_edge_timestamp_overwrite_ring.sv
// Self-checking bench for the edge timestamp ring: edge capture, reads and capture enable.
`timescale 1ns / 1ps

module tb_edge_timestamp_overwrite_ring;

    localparam int DEPTH         = etor_pkg::RING_DEPTH_DEF;
    localparam int MAXRD         = etor_pkg::MAX_READ_DEF;
    localparam int PTR_W         = $clog2(DEPTH);
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 12;
    localparam int RANDOM_ITEMS  = 470;
    localparam int WRAP_EDGES    = DEPTH + 18;

    // Ring contents, pointers and the queue of samples a read should return
    class ring_scoreboard;
        logic [31:0]        stamp_mem [DEPTH];
        logic               level_mem [DEPTH];
        logic [PTR_W-1:0]   wr_ptr;
        int                 fill;
        bit                 capturing;
        etor_pkg::result_t  expected_q[$];
        int                 errors;

        function new();
            wr_ptr    = '0;
            fill      = 0;
            capturing = 1'b0;
            errors    = 0;
        endfunction

        // Enabling from off clears the pointer and the count
        function void note_enable(logic v);
            if (v && !capturing)
            begin
                wr_ptr = '0;
                fill   = 0;
            end
            capturing = v;
        endfunction

        function void note_command(etor_pkg::cmd_t c);
            int                req;
            int                n;
            logic [PTR_W-1:0]  rd_ptr;
            etor_pkg::result_t r;
            if (c.op == etor_pkg::OP_EDGE)
            begin
                // Store the edge, overwriting the oldest once full
                if (capturing)
                begin
                    stamp_mem[wr_ptr] = c.edge_time;
                    level_mem[wr_ptr] = c.edge_level;
                    wr_ptr = wr_ptr + 1'b1;
                    if (fill < DEPTH)
                        fill++;
                end
            end
            else
            begin
                req = int'(c.max_count);
                if (req > MAXRD)
                    req = MAXRD;
                if (req == 0 || fill == 0)
                begin
                    // Empty read: one flagged result, store left as it is
                    r = '0;
                    r.is_empty    = 1'b1;
                    r.last_of_run = 1'b1;
                    expected_q.push_back(r);
                end
                else
                begin
                    // Return the oldest samples, then drop the rest
                    n      = (fill < req) ? fill : req;
                    rd_ptr = PTR_W'(int'(wr_ptr) + DEPTH - fill);
                    for (int i = 0; i < n; i++)
                    begin
                        r = '0;
                        r.sample_time  = stamp_mem[rd_ptr];
                        r.sample_level = level_mem[rd_ptr];
                        r.last_of_run  = (i == n - 1);
                        expected_q.push_back(r);
                        rd_ptr = rd_ptr + 1'b1;
                    end
                    fill = 0;
                end
            end
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(etor_pkg::result_t got);
            etor_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                $error("sample with nothing expected: time %0h level %0b",
                       got.sample_time, got.sample_level);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                compare("sample_time", want.sample_time, got.sample_time);
                compare("sample_level", 32'(want.sample_level), 32'(got.sample_level));
                compare("is_empty", 32'(want.is_empty), 32'(got.is_empty));
                compare("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    etor_pkg::cmd_t    cmd       = '0;
    logic              cfg_valid = 1'b0;
    logic              cfg_data  = 1'b0;
    logic              busy;
    logic              result_strobe;
    etor_pkg::result_t result;
    logic              cfg_ready;

    ring_scoreboard sb;
    bit             no_idle = 1'b0;
    int             idle_count = 0;

    edge_timestamp_overwrite_ring DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .result_strobe (result_strobe),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // Observe every transfer and watch for a stalled run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.note_enable(cfg_data);
            if (start && !busy)
                sb.note_command(cmd);
            if (result_strobe)
                sb.check_result(result);
            if ((cfg_valid && cfg_ready) || (start && !busy) || result_strobe)
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= IDLE_LIMIT)
            begin
                $display("tb_edge_timestamp_overwrite_ring: errors");
                $finish;
            end
        end
    end

    // Present one command and hold it until the block takes it
    task automatic send_cmd(input etor_pkg::cmd_t c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
    endtask

    task automatic send_edge(input logic [31:0] stamp, input logic lvl);
        etor_pkg::cmd_t c;
        c            = '0;
        c.op         = etor_pkg::OP_EDGE;
        c.edge_time  = stamp;
        c.edge_level = lvl;
        c.max_count  = 7'($urandom_range(0, 127));
        send_cmd(c);
    endtask

    task automatic send_read(input int limit);
        etor_pkg::cmd_t c;
        c            = '0;
        c.op         = etor_pkg::OP_READ;
        c.edge_time  = $urandom;
        c.edge_level = 1'($urandom_range(0, 1));
        c.max_count  = 7'(limit);
        send_cmd(c);
    endtask

    // Drop start and wait until the block has delivered everything
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 || busy) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_capture(input logic v);
        int gap;
        settle();
        gap = $urandom_range(0, 9);
        repeat (gap) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int counted;
        int n_items;
        int mode;
        int pick;
        int limit;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Read and edge while capture is off after reset
        send_read(5);
        send_edge($urandom, 1'b1);

        // Extreme stamps, zero and oversized limits, drained store
        set_capture(1'b1);
        send_edge(32'h0000_0000, 1'b0);
        send_edge(32'hFFFF_FFFF, 1'b1);
        send_edge($urandom, 1'($urandom_range(0, 1)));
        send_read(0);
        send_read(127);
        send_read(10);

        // Enable again while on, then a partial read
        set_capture(1'b1);
        repeat (5) send_edge($urandom, 1'($urandom_range(0, 1)));
        send_read(2);
        send_read(MAXRD);

        // Samples kept over a disable and read out while off
        repeat (3) send_edge($urandom, 1'($urandom_range(0, 1)));
        set_capture(1'b0);
        send_edge($urandom, 1'b0);
        send_read(MAXRD);
        send_read(1);

        // Fill past the depth so the oldest samples are overwritten
        set_capture(1'b1);
        no_idle = 1'b1;
        repeat (WRAP_EDGES) send_edge($urandom, 1'($urandom_range(0, 1)));
        no_idle = 1'b0;
        send_read(100);
        repeat (2) send_edge($urandom, 1'($urandom_range(0, 1)));
        send_read(MAXRD);

        // Random phases: capture mostly on, bursts of edges mixed with reads
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 7);
            if (mode == 0)
                set_capture(1'b0);
            else if (mode == 1)
                set_capture(1'b1);
            else if (mode == 2)
            begin
                set_capture(1'b0);
                set_capture(1'b1);
            end
            else if (!sb.capturing && mode < 6)
                set_capture(1'b1);
            no_idle = ($urandom_range(0, 3) == 0);
            n_items = $urandom_range(10, 40);
            for (int k = 0; k < n_items; k++)
            begin
                if ($urandom_range(0, 99) < 75)
                begin
                    if (sb.capturing)
                        counted++;
                    send_edge($urandom, 1'($urandom_range(0, 1)));
                end
                else
                begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        limit = 0;
                    else if (pick == 1)
                        limit = $urandom_range(MAXRD + 1, 127);
                    else if (pick == 2)
                        limit = MAXRD;
                    else
                        limit = $urandom_range(1, 20);
                    counted++;
                    send_read(limit);
                end
            end
            no_idle = 1'b0;
        end

        // Drain, then allow for stray samples
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected samples never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("tb_edge_timestamp_overwrite_ring: clean");
        else
            $display("tb_edge_timestamp_overwrite_ring: errors");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/etor_pkg.sv
sv/etor_addr_unit.sv
sv/etor_ring_mem.sv
sv/edge_timestamp_overwrite_ring.sv
bench/tb_edge_timestamp_overwrite_ring.sv
